// File: sv/textured_rect_clipper_core_macros.svh
// ----------------------------------------------------------------------------
// Textured rectangle clipper assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_RECT_CLIPPER_CORE_MACROS_SVH
`define TEXTURED_RECT_CLIPPER_CORE_MACROS_SVH

// clocked assertion, disabled while reset is low
`define TRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/trc_pkg.sv
// ----------------------------------------------------------------------------
// Textured rectangle clipper package
// Field widths, request and result types, register indexes and saturation.
// ----------------------------------------------------------------------------
package trc_pkg;

    localparam int COORD_W = 16;
    localparam int TAG_W   = 16;
    localparam int SPAN_W  = COORD_W - 1;
    localparam int DIF_W   = COORD_W + 1;
    localparam int NUM_W   = COORD_W + 2;
    localparam int PROD_W  = 2 * COORD_W + 1;
    localparam int RES_W   = PROD_W + 2;
    localparam int INTERP_LAT = PROD_W + 3;
    localparam int LATENCY = 2 * INTERP_LAT + 2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [TAG_W-1:0] texture_handle;
        t_coord           left_x;
        t_coord           top_y;
        t_coord           right_x;
        t_coord           bottom_y;
        t_coord           tex_s_start;
        t_coord           tex_t_start;
        t_coord           tex_s_end;
        t_coord           tex_t_end;
    } t_req;

    typedef struct packed {
        logic [TAG_W-1:0] out_texture;
        t_coord           out_left_x;
        t_coord           out_top_y;
        t_coord           out_right_x;
        t_coord           out_bottom_y;
        t_coord           out_s_start;
        t_coord           out_t_start;
        t_coord           out_s_end;
        t_coord           out_t_end;
    } t_rsp;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        t_coord           c_lo;
        t_coord           c_hi;
        t_coord           t_keep;
    } t_lane;

    typedef enum logic [1:0] {
        CFG_CLIP_LEFT = 2'd0,
        CFG_CLIP_TOP  = 2'd1,
        CFG_SPAN_X    = 2'd2,
        CFG_SPAN_Y    = 2'd3
    } t_cfg_idx;

    function automatic t_coord sat_coord(input logic signed [RES_W-1:0] v);
        t_coord r;
        if ((&v[RES_W-1:COORD_W-1]) || !(|v[RES_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end else if (v[RES_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: sv/trc_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step; shifts a dividend bit in, a quotient bit out.
// ----------------------------------------------------------------------------
module trc_div_cell #(
    parameter int DIV_W  = 16,
    parameter int PQ_W   = 33,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [PQ_W-1:0]   i_pq,
    input  logic [DIV_W-1:0]  i_d,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [DIV_W-1:0]  o_rem,
    output logic [PQ_W-1:0]   o_pq,
    output logic [DIV_W-1:0]  o_d,
    output logic [SIDE_W-1:0] o_side
);

    logic [DIV_W:0]   trial;
    logic [DIV_W+1:0] diff;
    logic             ge;
    logic [DIV_W-1:0] n_rem;
    logic [PQ_W-1:0]  n_pq;

    always_comb begin
        trial = {i_rem, i_pq[PQ_W-1]};
        diff  = {1'b0, trial} - {2'b00, i_d};
        ge    = !diff[DIV_W+1];
        n_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_pq  = {i_pq[PQ_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_pq   <= n_pq;
        o_d    <= i_d;
        o_side <= i_side;
    end

endmodule

// File: sv/trc_interp.sv
// ----------------------------------------------------------------------------
// Edge interpolator
// base + num * dt / den, truncated toward zero and saturated, over a cell row.
// ----------------------------------------------------------------------------
module trc_interp #(
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic                              i_en,
    input  trc_pkg::t_coord                   i_base,
    input  logic signed [trc_pkg::NUM_W-1:0]  i_num,
    input  logic signed [trc_pkg::DIF_W-1:0]  i_dt,
    input  logic signed [trc_pkg::DIF_W-1:0]  i_den,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_vld,
    output trc_pkg::t_coord                   o_res,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int CW   = trc_pkg::COORD_W;
    localparam int PW   = trc_pkg::PROD_W;
    localparam int NW   = trc_pkg::NUM_W;
    localparam int DW   = trc_pkg::DIF_W;
    localparam int RW   = trc_pkg::RES_W;
    localparam int CS_W = SIDE_W + CW + 2;

    logic                   r0_vld;
    logic                   r0_en;
    trc_pkg::t_coord        r0_base;
    logic signed [NW-1:0]   r0_num;
    logic signed [DW-1:0]   r0_dt;
    logic signed [DW-1:0]   r0_den;
    logic [SIDE_W-1:0]      r0_side;

    logic signed [NW-1:0]   num_abs;
    logic signed [DW-1:0]   dt_abs;
    logic signed [DW-1:0]   den_abs;
    logic                   neg;
    logic                   en1;
    logic [PW-1:0]          n_prod;
    logic [CS_W-1:0]        n_cs;

    logic                   r1_vld;
    logic [PW-1:0]          r1_pq;
    logic [CW-1:0]          r1_d;
    logic [CS_W-1:0]        r1_cs;

    logic                   c_vld  [PW+1];
    logic [CW-1:0]          c_rem  [PW+1];
    logic [PW-1:0]          c_pq   [PW+1];
    logic [CW-1:0]          c_d    [PW+1];
    logic [CS_W-1:0]        c_cs   [PW+1];

    logic                   fin_en;
    logic                   fin_neg;
    trc_pkg::t_coord        fin_base;
    logic [SIDE_W-1:0]      fin_side;
    logic signed [RW-1:0]   b_ext;
    logic signed [RW-1:0]   q_ext;
    logic signed [RW-1:0]   sum;
    trc_pkg::t_coord        n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            o_vld  <= c_vld[PW];
        end
    end

    always_ff @(posedge i_clk) begin
        r0_en   <= i_en;
        r0_base <= i_base;
        r0_num  <= i_num;
        r0_dt   <= i_dt;
        r0_den  <= i_den;
        r0_side <= i_side;
    end

    always_comb begin
        num_abs = r0_num[NW-1] ? -r0_num : r0_num;
        dt_abs  = r0_dt[DW-1] ? -r0_dt : r0_dt;
        den_abs = r0_den[DW-1] ? -r0_den : r0_den;
        neg     = r0_num[NW-1] ^ r0_dt[DW-1] ^ r0_den[DW-1];
        en1     = r0_en && (r0_den != '0);
        n_prod  = PW'(num_abs[CW:0]) * PW'(dt_abs[CW-1:0]);
        n_cs    = {r0_side, r0_base, neg, en1};
    end

    always_ff @(posedge i_clk) begin
        r1_pq <= n_prod;
        r1_d  <= den_abs[CW-1:0];
        r1_cs <= n_cs;
    end

    assign c_vld[0] = r1_vld;
    assign c_rem[0] = '0;
    assign c_pq[0]  = r1_pq;
    assign c_d[0]   = r1_d;
    assign c_cs[0]  = r1_cs;

    for (genvar k = 0; k < PW; k++) begin : g_cell
        trc_div_cell #(
            .DIV_W  (CW),
            .PQ_W   (PW),
            .SIDE_W (CS_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[k]),
            .i_rem   (c_rem[k]),
            .i_pq    (c_pq[k]),
            .i_d     (c_d[k]),
            .i_side  (c_cs[k]),
            .o_vld   (c_vld[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_pq    (c_pq[k+1]),
            .o_d     (c_d[k+1]),
            .o_side  (c_cs[k+1])
        );
    end

    always_comb begin
        fin_en   = c_cs[PW][0];
        fin_neg  = c_cs[PW][1];
        fin_base = c_cs[PW][CW+1:2];
        fin_side = c_cs[PW][CS_W-1:CW+2];
        b_ext    = RW'(fin_base);
        q_ext    = $signed(RW'(c_pq[PW]));
        sum      = fin_neg ? (b_ext - q_ext) : (b_ext + q_ext);
        n_res    = fin_en ? trc_pkg::sat_coord(sum) : fin_base;
    end

    always_ff @(posedge i_clk) begin
        o_res  <= n_res;
        o_side <= fin_side;
    end

endmodule

// File: sv/textured_rect_clipper_core.sv
// ----------------------------------------------------------------------------
// Textured rectangle clipper core
// Clips a textured rectangle to the window, moving texture coordinates along.
// ----------------------------------------------------------------------------
// Path: input register, left and top clips, right and bottom clips, result register.
// Throughput: one rectangle per cycle; busy drops the cycle after reset and stays low.
// Each clip runs a 33-cell restoring divider row; x and y lanes run side by side.
// Reset clears the window to origin 0,0 with span 32767 and drops work in flight.
// The receiver cannot stall; a result is shown for one cycle only.
module textured_rect_clipper_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  trc_pkg::t_req                 i_req,
    output logic                          o_valid,
    output trc_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  trc_pkg::t_cfg_idx             i_cfg_index,
    input  logic [trc_pkg::COORD_W-1:0]   i_cfg_data
);

    localparam int CW  = trc_pkg::COORD_W;
    localparam int SW  = trc_pkg::SPAN_W;
    localparam int NW  = trc_pkg::NUM_W;
    localparam int DW  = trc_pkg::DIF_W;
    localparam int LW  = $bits(trc_pkg::t_lane);

    logic                  r_live;
    trc_pkg::t_coord       r_clip_left;
    trc_pkg::t_coord       r_clip_top;
    logic [SW-1:0]         r_span_x;
    logic [SW-1:0]         r_span_y;
    logic signed [DW-1:0]  r_edge_right;
    logic signed [DW-1:0]  r_edge_bottom;

    logic                  r_in_vld;
    trc_pkg::t_req         r_in;

    logic                  xl_en, yl_en, xr_en, yr_en;
    logic signed [NW-1:0]  xl_num, yl_num, xr_num, yr_num;
    logic signed [DW-1:0]  xl_dt, yl_dt, xr_dt, yr_dt;
    logic signed [DW-1:0]  xl_den, yl_den, xr_den, yr_den;
    trc_pkg::t_lane        xl_side, yl_side, xr_side, yr_side;

    logic                  xm_vld, ym_vld, xo_vld, yo_vld;
    trc_pkg::t_coord       xm_res, ym_res, xo_res, yo_res;
    trc_pkg::t_lane        xm_side, ym_side, xo_side, yo_side;

    logic                  n_valid;
    trc_pkg::t_rsp         n_rsp;

    assign busy        = !r_live;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= 1'b0;
            r_in_vld    <= 1'b0;
            o_valid     <= 1'b0;
            r_clip_left <= '0;
            r_clip_top  <= '0;
            r_span_x    <= '1;
            r_span_y    <= '1;
        end else begin
            r_live   <= 1'b1;
            r_in_vld <= start && !busy;
            o_valid  <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    trc_pkg::CFG_CLIP_LEFT: r_clip_left <= i_cfg_data;
                    trc_pkg::CFG_CLIP_TOP:  r_clip_top  <= i_cfg_data;
                    trc_pkg::CFG_SPAN_X:    r_span_x    <= i_cfg_data[SW-1:0];
                    trc_pkg::CFG_SPAN_Y:    r_span_y    <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge_right  <= DW'(r_clip_left) + $signed(DW'(r_span_x));
        r_edge_bottom <= DW'(r_clip_top) + $signed(DW'(r_span_y));
        r_in          <= i_req;
        o_rsp         <= n_rsp;
    end

    // left and top clips
    always_comb begin
        xl_en          = r_in.left_x < r_clip_left;
        xl_num         = NW'(r_clip_left) - NW'(r_in.left_x);
        xl_dt          = DW'(r_in.tex_s_end) - DW'(r_in.tex_s_start);
        xl_den         = DW'(r_in.right_x) - DW'(r_in.left_x);
        xl_side.tag    = r_in.texture_handle;
        xl_side.c_lo   = xl_en ? r_clip_left : r_in.left_x;
        xl_side.c_hi   = r_in.right_x;
        xl_side.t_keep = r_in.tex_s_end;

        yl_en          = r_in.top_y < r_clip_top;
        yl_num         = NW'(r_clip_top) - NW'(r_in.top_y);
        yl_dt          = DW'(r_in.tex_t_end) - DW'(r_in.tex_t_start);
        yl_den         = DW'(r_in.bottom_y) - DW'(r_in.top_y);
        yl_side.tag    = '0;
        yl_side.c_lo   = yl_en ? r_clip_top : r_in.top_y;
        yl_side.c_hi   = r_in.bottom_y;
        yl_side.t_keep = r_in.tex_t_end;
    end

    trc_interp #(.SIDE_W(LW)) u_clip_left (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_in_vld), .i_en (xl_en),
        .i_base (r_in.tex_s_start), .i_num (xl_num), .i_dt (xl_dt), .i_den (xl_den),
        .i_side (xl_side), .o_vld (xm_vld), .o_res (xm_res), .o_side (xm_side)
    );

    trc_interp #(.SIDE_W(LW)) u_clip_top (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_in_vld), .i_en (yl_en),
        .i_base (r_in.tex_t_start), .i_num (yl_num), .i_dt (yl_dt), .i_den (yl_den),
        .i_side (yl_side), .o_vld (ym_vld), .o_res (ym_res), .o_side (ym_side)
    );

    // right and bottom clips on the updated near edge
    always_comb begin
        xr_en          = NW'(xm_side.c_hi) > NW'(r_edge_right);
        xr_num         = NW'(r_edge_right) - NW'(xm_side.c_hi);
        xr_dt          = DW'(xm_side.t_keep) - DW'(xm_res);
        xr_den         = DW'(xm_side.c_hi) - DW'(xm_side.c_lo);
        xr_side.tag    = xm_side.tag;
        xr_side.c_lo   = xm_side.c_lo;
        xr_side.c_hi   = xr_en ? r_edge_right[CW-1:0] : xm_side.c_hi;
        xr_side.t_keep = xm_res;

        yr_en          = NW'(ym_side.c_hi) > NW'(r_edge_bottom);
        yr_num         = NW'(r_edge_bottom) - NW'(ym_side.c_hi);
        yr_dt          = DW'(ym_side.t_keep) - DW'(ym_res);
        yr_den         = DW'(ym_side.c_hi) - DW'(ym_side.c_lo);
        yr_side.tag    = ym_side.tag;
        yr_side.c_lo   = ym_side.c_lo;
        yr_side.c_hi   = yr_en ? r_edge_bottom[CW-1:0] : ym_side.c_hi;
        yr_side.t_keep = ym_res;
    end

    trc_interp #(.SIDE_W(LW)) u_clip_right (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (xm_vld), .i_en (xr_en),
        .i_base (xm_side.t_keep), .i_num (xr_num), .i_dt (xr_dt), .i_den (xr_den),
        .i_side (xr_side), .o_vld (xo_vld), .o_res (xo_res), .o_side (xo_side)
    );

    trc_interp #(.SIDE_W(LW)) u_clip_bottom (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (ym_vld), .i_en (yr_en),
        .i_base (ym_side.t_keep), .i_num (yr_num), .i_dt (yr_dt), .i_den (yr_den),
        .i_side (yr_side), .o_vld (yo_vld), .o_res (yo_res), .o_side (yo_side)
    );

    // drop empty rectangles
    always_comb begin
        n_valid            = xo_vld && yo_vld &&
                             (xo_side.c_lo < xo_side.c_hi) &&
                             (yo_side.c_lo < yo_side.c_hi);
        n_rsp.out_texture  = xo_side.tag;
        n_rsp.out_left_x   = xo_side.c_lo;
        n_rsp.out_top_y    = yo_side.c_lo;
        n_rsp.out_right_x  = xo_side.c_hi;
        n_rsp.out_bottom_y = yo_side.c_hi;
        n_rsp.out_s_start  = xo_side.t_keep;
        n_rsp.out_t_start  = yo_side.t_keep;
        n_rsp.out_s_end    = xo_res;
        n_rsp.out_t_end    = yo_res;
    end

endmodule

// File: sv/trc_checker.sv
// ----------------------------------------------------------------------------
// Textured rectangle clipper checker
// Port-level checks on request acceptance and result strobes.
// ----------------------------------------------------------------------------
`include "textured_rect_clipper_core_macros.svh"

module trc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input trc_pkg::t_rsp o_rsp
);

    `TRC_ASSERT(a_busy_low, i_clk, i_rst_n, $past(i_rst_n) |-> !busy, "busy after reset")
    `TRC_ASSERT(a_rsp_has_req, i_clk, i_rst_n, o_valid |-> $past(start && !busy, trc_pkg::LATENCY), "result without request")
    `TRC_ASSERT(a_rsp_nonempty, i_clk, i_rst_n, o_valid |-> ((o_rsp.out_left_x < o_rsp.out_right_x) && (o_rsp.out_top_y < o_rsp.out_bottom_y)), "empty rectangle emitted")
    `TRC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "strobe after reset")

endmodule

bind textured_rect_clipper_core trc_checker u_trc_checker (.*);

// File: test/textured_rect_clipper_core_checker.sv
// ----------------------------------------------------------------------------
// Textured rectangle clipper checker
// Watches the request, result and register channels, predicts each clipped
// rectangle and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module textured_rect_clipper_core_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  trc_pkg::t_req     i_req,
    input  logic              i_valid,
    input  trc_pkg::t_rsp     i_rsp,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  trc_pkg::t_cfg_idx i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    longint        win_left;
    longint        win_top;
    longint        win_span_x;
    longint        win_span_y;
    trc_pkg::t_rsp clipped_q[$];
    int            fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = clipped_q.size();

    // base + num * dt / den, truncated toward zero, saturated to 16 bits
    function automatic longint lerp_coord(longint base, longint num, longint dt,
                                          longint den);
        longint q;
        longint r;
        if (den == 0) begin
            return base;
        end
        q = (num * dt) / den;
        r = base + q;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return r;
    endfunction

    function automatic bit clip_rect(trc_pkg::t_req rq, output trc_pkg::t_rsp rs);
        longint x1;
        longint y1;
        longint x2;
        longint y2;
        longint s1;
        longint t1;
        longint s2;
        longint t2;
        longint edge_v;
        x1 = rq.left_x;
        y1 = rq.top_y;
        x2 = rq.right_x;
        y2 = rq.bottom_y;
        s1 = rq.tex_s_start;
        t1 = rq.tex_t_start;
        s2 = rq.tex_s_end;
        t2 = rq.tex_t_end;
        edge_v = win_left;
        if (x1 < edge_v) begin
            s1 = lerp_coord(s1, edge_v - x1, s2 - s1, x2 - x1);
            x1 = edge_v;
        end
        edge_v = win_left + win_span_x;
        if (x2 > edge_v) begin
            s2 = lerp_coord(s2, edge_v - x2, s2 - s1, x2 - x1);
            x2 = edge_v;
        end
        edge_v = win_top;
        if (y1 < edge_v) begin
            t1 = lerp_coord(t1, edge_v - y1, t2 - t1, y2 - y1);
            y1 = edge_v;
        end
        edge_v = win_top + win_span_y;
        if (y2 > edge_v) begin
            t2 = lerp_coord(t2, edge_v - y2, t2 - t1, y2 - y1);
            y2 = edge_v;
        end
        rs.out_texture  = rq.texture_handle;
        rs.out_left_x   = trc_pkg::t_coord'(x1);
        rs.out_top_y    = trc_pkg::t_coord'(y1);
        rs.out_right_x  = trc_pkg::t_coord'(x2);
        rs.out_bottom_y = trc_pkg::t_coord'(y2);
        rs.out_s_start  = trc_pkg::t_coord'(s1);
        rs.out_t_start  = trc_pkg::t_coord'(t1);
        rs.out_s_end    = trc_pkg::t_coord'(s2);
        rs.out_t_end    = trc_pkg::t_coord'(t2);
        return (x1 < x2) && (y1 < y2);
    endfunction

    always @(posedge i_clk) begin
        trc_pkg::t_rsp want;
        if (!i_rst_n) begin
            win_left   = 0;
            win_top    = 0;
            win_span_x = 32767;
            win_span_y = 32767;
            fail_count = 0;
            clipped_q.delete();
        end else begin
            if (i_valid) begin
                if (clipped_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result %h", i_rsp);
                    end
                end else begin
                    want = clipped_q.pop_front();
                    if (want !== i_rsp) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %h actual %h", want, i_rsp);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (clip_rect(i_req, want)) begin
                    clipped_q.push_back(want);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    trc_pkg::CFG_CLIP_LEFT: win_left = longint'($signed(i_cfg_data));
                    trc_pkg::CFG_CLIP_TOP:  win_top = longint'($signed(i_cfg_data));
                    trc_pkg::CFG_SPAN_X:    win_span_x = longint'(i_cfg_data[14:0]);
                    trc_pkg::CFG_SPAN_Y:    win_span_y = longint'(i_cfg_data[14:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: test/textured_rect_clipper_core_tb.sv
// ----------------------------------------------------------------------------
// Textured rectangle clipper testbench
// Drives directed and random rectangles under several clip windows with
// random request gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module textured_rect_clipper_core_tb;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    trc_pkg::t_req     i_req;
    logic              o_valid;
    trc_pkg::t_rsp     o_rsp;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    trc_pkg::t_cfg_idx i_cfg_index;
    logic [15:0]       i_cfg_data;
    int                fail_count;
    int                pending;

    textured_rect_clipper_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    textured_rect_clipper_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_req(i_req), .i_valid(o_valid), .i_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 1200)) - 300);
        endcase
    endfunction

    function automatic trc_pkg::t_req random_rect();
        trc_pkg::t_req r;
        r = trc_pkg::t_req'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        r.left_x   = pick_coord();
        r.top_y    = pick_coord();
        r.right_x  = pick_coord();
        r.bottom_y = pick_coord();
        if ($urandom_range(0, 3) != 0) begin
            if (r.left_x > r.right_x) begin
                {r.left_x, r.right_x} = {r.right_x, r.left_x};
            end
            if (r.top_y > r.bottom_y) begin
                {r.top_y, r.bottom_y} = {r.bottom_y, r.top_y};
            end
        end
        if ($urandom_range(0, 15) == 0) begin
            r.right_x = r.left_x;
        end
        return r;
    endfunction

    task automatic send_rect(trc_pkg::t_req r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (trc_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(trc_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_window(logic [15:0] l, logic [15:0] t, logic [15:0] sx,
                              logic [15:0] sy);
        write_reg(trc_pkg::CFG_CLIP_LEFT, l);
        write_reg(trc_pkg::CFG_CLIP_TOP, t);
        write_reg(trc_pkg::CFG_SPAN_X, sx);
        write_reg(trc_pkg::CFG_SPAN_Y, sy);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        trc_pkg::t_req r;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = trc_pkg::CFG_CLIP_LEFT;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset window, extremes, zero span, overflow, inverted
        send_rect('{16'hffff, -16'sd100, -16'sd50, 16'sd400, 16'sd300,
                    16'sd0, 16'sd0, 16'sd1000, 16'sd2000});
        send_rect('{16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                    16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        send_rect('{16'h1234, -16'sd10, -16'sd10, -16'sd10, 16'sd50,
                    16'sd5, 16'sd6, 16'sd7, 16'sd8});
        send_rect('{16'h5555, 16'sd500, 16'sd10, 16'sd100, 16'sd60,
                    16'sd1, 16'sd2, 16'sd3, 16'sd4});
        send_rect('{16'haaaa, -16'sd32768, 16'sd0, 16'sd1, 16'sd20,
                    16'sd32767, 16'sd0, -16'sd32768, 16'sd9});
        drain();
        set_window(16'h0100, 16'hff00, 16'd2048, 16'd1024);
        send_rect('{16'h0001, 16'sd0, -16'sd512, 16'sd4000, 16'sd2000,
                    -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
        send_rect('{16'h0002, 16'sd300, 16'sd0, 16'sd900, 16'sd100,
                    16'sd10, 16'sd20, 16'sd30, 16'sd40});
        send_rect('{16'h0003, 16'sd300, 16'sd0, 16'sd200, 16'sd100,
                    16'sd10, 16'sd20, 16'sd30, 16'sd40});
        drain();
        set_window(16'h7fff, 16'h8000, 16'd32767, 16'd0);
        send_rect('{16'h0004, 16'sd0, -16'sd32768, 16'sd32767, 16'sd100,
                    16'sd0, 16'sd1, 16'sd2, 16'sd3});
        drain();
        set_window(16'h8000, 16'h8000, 16'd32767, 16'd32767);
        send_rect('{16'h0005, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                    16'sd1, 16'sd2, 16'sd3, 16'sd4});

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase % 4)
                0: set_window(16'($signed($urandom_range(0, 400)) - 200),
                              16'($signed($urandom_range(0, 400)) - 200),
                              16'($urandom_range(0, 800)), 16'($urandom_range(0, 800)));
                1: set_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                2: set_window(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
                default: set_window(16'sd0, 16'sd0, 16'd600, 16'd600);
            endcase
            for (int k = 0; k < 50; k++) begin
                r = random_rect();
                send_rect(r);
            end
        end
        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/trc_pkg.sv
sv/trc_div_cell.sv
sv/trc_interp.sv
sv/textured_rect_clipper_core.sv
sv/trc_checker.sv
test/textured_rect_clipper_core_checker.sv
test/textured_rect_clipper_core_tb.sv
